// ===== rtl/s256_pkg.sv =====
`timescale 1ns / 1ps
package s256_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic load;
    logic round;
    logic fold;
    logic restart;
  } ctl_cmd_t;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

endpackage

// ===== rtl/s256_if.sv =====
`timescale 1ns / 1ps
interface s256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface s256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/s256_core.sv =====
`timescale 1ns / 1ps
module s256_core
  import s256_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctl_cmd_t   cmd_i,
  input  logic [5:0] round_i,
  input  word_t      blk_i [16],
  input  logic [2:0] rd_idx_i,
  output word_t      rd_word_o
);

  word_t h_q [8];
  word_t v_q [8];
  word_t w_q [16];
  word_t w_new, wt, t1, t2, s0, s1, ch, mj, ls0, ls1;

  always_comb begin
    ls1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
          ^ (w_q[14] >> 10);
    ls0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
    w_new = ls1 + w_q[9] + ls0 + w_q[0];
    wt = (round_i < 6'd16) ? w_q[round_i[3:0]] : w_new;
    s1 = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
         ^ {v_q[4][24:0], v_q[4][31:25]};
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1 = v_q[7] + s1 + ch + RoundK[round_i] + wt;
    s0 = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
         ^ {v_q[0][21:0], v_q[0][31:22]};
    mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2 = s0 + mj;
  end

  assign rd_word_o = h_q[rd_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
    end else if (cmd_i.restart) begin
      for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
    end else if (cmd_i.fold) begin
      for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 16; i++) w_q[i] <= blk_i[i];
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.round) begin
      if (round_i >= 6'd16) begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= w_new;
      end
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

endmodule

// ===== rtl/s256_ctrl.sv =====
`timescale 1ns / 1ps
module s256_ctrl
  import s256_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  s256_in_if.sink       in_if,
  s256_out_if.source    out_if,
  output ctl_cmd_t      cmd_o,
  output logic [5:0]    round_o,
  output word_t         blk_o [16],
  output logic [2:0]    rd_idx_o,
  input  word_t         rd_word_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROUND, ST_FOLD, ST_PAD, ST_EMIT
  } state_e;

  state_e      state_q;
  logic [31:0] buf_q [16];
  logic [31:0] pad_blk [16];
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [5:0]  round_q;
  logic        fin_q;
  logic        lenblk_q;
  logic [2:0]  idx_q;
  logic        ovalid_q;
  logic [31:0] oword_q;
  logic        mark_q;
  logic        acc;
  ctl_cmd_t    cmd_d;

  assign in_if.ready = (state_q == ST_IDLE);
  assign acc = in_if.valid && in_if.ready;
  assign round_o = round_q;
  assign rd_idx_o = idx_q;
  assign out_if.valid = ovalid_q;
  assign out_if.digest_word = oword_q;
  assign out_if.word_index = idx_q - 3'd1;
  assign out_if.last_word = (idx_q == 3'd0);

  always_comb begin
    for (int i = 0; i < 16; i++) blk_o[i] = buf_q[i];
  end

  always_comb begin
    cmd_d = '0;
    unique case (state_q)
      ST_IDLE:  cmd_d.load = acc && in_if.byte_valid && (fill_q == 6'd63);
      ST_ROUND: cmd_d.round = !(cmd_o.round && round_q == 6'd63);
      ST_FOLD:  cmd_d.fold = !cmd_o.fold;
      ST_PAD:   cmd_d.load = 1'b1;
      ST_EMIT:  cmd_d.restart = ovalid_q && out_if.ready && (idx_q == 3'd0);
      default:  cmd_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q <= '0;
      bits_q <= '0;
      round_q <= '0;
      fin_q <= 1'b0;
      lenblk_q <= 1'b0;
      idx_q <= '0;
      ovalid_q <= 1'b0;
      oword_q <= '0;
      cmd_o <= '0;
    end else begin
      cmd_o <= cmd_d;
      unique case (state_q)
        ST_IDLE: begin
          if (acc) begin
            fin_q <= in_if.end_of_message;
            lenblk_q <= 1'b0;
            if (in_if.byte_valid) begin
              bits_q <= bits_q + 64'd8;
              fill_q <= fill_q + 6'd1;
              if (fill_q == 6'd63) begin
                round_q <= '0;
                state_q <= ST_ROUND;
              end else if (in_if.end_of_message) begin
                state_q <= ST_PAD;
              end
            end else if (in_if.end_of_message) begin
              state_q <= ST_PAD;
            end
          end
        end
        ST_ROUND: begin
          if (cmd_o.round) begin
            round_q <= round_q + 6'd1;
            if (round_q == 6'd63) state_q <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          if (cmd_o.fold) begin
            if (lenblk_q) begin
              idx_q <= '0;
              state_q <= ST_EMIT;
            end else if (fin_q) state_q <= ST_PAD;
            else state_q <= ST_IDLE;
          end
        end
        ST_PAD: begin
          // buffer write happens below; go compress
          if (fill_q < LenPos) lenblk_q <= 1'b1;
          fill_q <= '0;
          round_q <= '0;
          state_q <= ST_ROUND;
        end
        ST_EMIT: begin
          if (!ovalid_q || out_if.ready) begin
            if (ovalid_q && idx_q == 3'd0) begin
              ovalid_q <= 1'b0;
              bits_q <= '0;
              fill_q <= '0;
              fin_q <= 1'b0;
              state_q <= ST_IDLE;
            end else begin
              ovalid_q <= 1'b1;
              oword_q <= rd_word_i;
              idx_q <= idx_q + 3'd1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // pad marker flag: set by the first pad pass of a finalize, cleared in idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mark_q <= 1'b0;
    else if (state_q == ST_IDLE) mark_q <= 1'b0;
    else if (state_q == ST_PAD) mark_q <= 1'b1;
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      pad_blk[i] = buf_q[i];
      for (int j = 0; j < 4; j++) begin
        if (6'(4*i+j) >= fill_q) begin
          if (!mark_q && 6'(4*i+j) == fill_q) pad_blk[i][8*(3-j) +: 8] = PadByte;
          else pad_blk[i][8*(3-j) +: 8] = 8'h00;
        end
      end
    end
    if (mark_q || fill_q < LenPos) begin
      pad_blk[14] = bits_q[63:32];
      pad_blk[15] = bits_q[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PAD) begin
      for (int i = 0; i < 16; i++) buf_q[i] <= pad_blk[i];
    end else if (acc && in_if.byte_valid) begin
      buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= in_if.data_byte;
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> !ovalid_q) else $error("ready while emitting");
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cmd_o) <= 1) else $error("overlapping commands");
  a_emit_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> state_q == ST_EMIT) else $error("output outside emit");
`endif

endmodule

// ===== rtl/sha256_stream_hash_top.sv =====
`timescale 1ns / 1ps
// sha-256 over a byte stream
// input channel in_if: one item per byte with byte_valid and end_of_message;
//   byte_valid low with end_of_message high finalizes the current message
// output channel out_if: eight digest words, word_index 0..7, last_word on 7
// after the 64th byte of a block input is not ready while the block is loaded,
//   compressed in 64 rounds at one per cycle and folded into the hash
// input takes bytes only in idle, never while a block is being compressed
// a finalize adds one or two padded blocks, each loaded, compressed and folded;
//   the first digest word follows the last fold, then one word per cycle while
//   the receiver is ready
// the output holds its word while the receiver stalls; no input is taken
//   until the last word is delivered
// after the digest the hash restarts from the initial values
// reset loads the initial values and clears counts; no clearing pass
module sha256_stream_hash_top
  import s256_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  s256_in_if.sink    in_if,
  s256_out_if.source out_if
);

  ctl_cmd_t   cmd;
  logic [5:0] round;
  word_t      blk [16];
  logic [2:0] rd_idx;
  word_t      rd_word;

  s256_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_if, .out_if,
    .cmd_o(cmd), .round_o(round), .blk_o(blk), .rd_idx_o(rd_idx), .rd_word_i(rd_word)
  );

  s256_core u_core (
    .clk_i, .rst_ni, .cmd_i(cmd), .round_i(round), .blk_i(blk),
    .rd_idx_i(rd_idx), .rd_word_o(rd_word)
  );

endmodule
